### hw/rtl/rotq_pkg.sv
// Shared types and codes for the rotating id queue.
package rotq_pkg;

   typedef enum logic [1:0] {
      REQ_REGISTER = 2'd0,
      REQ_ROTATE   = 2'd1,
      REQ_REMOVE   = 2'd2,
      REQ_NONE     = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_FEW       = 3'd2,
      ST_EMPTY     = 3'd3,
      ST_NOTFOUND  = 3'd4,
      ST_EXHAUSTED = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_REG,
      S_ROT_RD,
      S_ROT_WR,
      S_SCAN,
      S_DRAIN,
      S_HEAD_RD,
      S_HEAD_CAP
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic reg_exec;
      logic rot_read;
      logic rot_write;
      logic mark_empty;
      logic scan_issue;
      logic scan_proc;
      logic remove_finish;
      logic head_read;
      logic capture;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic empty;
      logic few;
      logic scan_last;
   } dp_stat_type;

endpackage

### hw/rtl/rotq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rotq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/rotq_ctrl.sv
// Sequencing state machine for the rotating id queue.
module rotq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_type,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rotq_pkg::dp_stat_type stat,
   output rotq_pkg::dp_cmd_type  cmd
);
   import rotq_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      req_ready    = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            // A new request waits until the previous result has been taken.
            req_ready = !rsp_valid_ff;
            if (req_valid && !rsp_valid_ff) begin
               cmd.load = 1'b1;
               unique case (req_kind_type'(req_type))
                  REQ_REGISTER: state_in = S_REG;
                  REQ_ROTATE:   state_in = S_ROT_RD;
                  REQ_REMOVE:   state_in = S_SCAN;
                  REQ_NONE:     state_in = S_HEAD_RD;
                  default:      state_in = S_HEAD_RD;
               endcase
            end
         end
         S_REG: begin
            cmd.reg_exec = 1'b1;
            state_in     = S_HEAD_RD;
         end
         S_ROT_RD: begin
            cmd.rot_read = 1'b1;
            state_in     = stat.few ? S_HEAD_RD : S_ROT_WR;
         end
         S_ROT_WR: begin
            cmd.rot_write = 1'b1;
            state_in      = S_HEAD_RD;
         end
         S_SCAN: begin
            if (stat.empty) begin
               cmd.mark_empty = 1'b1;
               state_in       = S_HEAD_RD;
            end else begin
               cmd.scan_issue = 1'b1;
               cmd.scan_proc  = 1'b1;
               if (stat.scan_last) begin
                  state_in = S_DRAIN;
               end
            end
         end
         S_DRAIN: begin
            cmd.scan_proc     = 1'b1;
            cmd.remove_finish = 1'b1;
            state_in          = S_HEAD_RD;
         end
         S_HEAD_RD: begin
            cmd.head_read = 1'b1;
            state_in      = S_HEAD_CAP;
         end
         S_HEAD_CAP: begin
            cmd.capture  = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### hw/rtl/rotq_dp.sv
// Queue pointers, id counter, entry memory and result registers.
module rotq_dp #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 16,
   parameter int TAG_BITS    = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  rotq_pkg::dp_cmd_type             cmd,
   output rotq_pkg::dp_stat_type            stat,
   input  logic [TAG_BITS-1:0]              req_driver_tag,
   input  logic [ID_BITS-1:0]               req_target_id,
   output rotq_pkg::status_type             rsp_status,
   output logic [ID_BITS-1:0]               rsp_assigned_id,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0] rsp_entry_count,
   output logic [ID_BITS-1:0]               rsp_head_id,
   output logic [TAG_BITS-1:0]              rsp_head_tag
);
   import rotq_pkg::*;

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int WORD_W = ID_BITS + TAG_BITS;

   localparam logic [PTR_W-1:0]   LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0]   FULL_CNT  = CNT_W'(QUEUE_DEPTH);
   localparam logic [ID_BITS-1:0] MAX_ID    = '1;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
      return (p == LAST_SLOT) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] wrap_dec(input logic [PTR_W-1:0] p);
      return (p == '0) ? LAST_SLOT : p - 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
                                                 input logic [PTR_W-1:0] b);
      logic [PTR_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (PTR_W + 1)'(QUEUE_DEPTH)) begin
         s = s - (PTR_W + 1)'(QUEUE_DEPTH);
      end
      return s[PTR_W-1:0];
   endfunction

   // Queue state.
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   occ_ff, occ_in;
   logic [ID_BITS-1:0] next_id_ff, next_id_in;
   logic               spent_ff, spent_in;

   // Per-request working registers.
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic [ID_BITS-1:0]  target_ff, target_in;
   logic [PTR_W-1:0]    scan_idx_ff, scan_idx_in;
   logic [PTR_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                rd_valid_ff, rd_valid_in;
   logic                hit_ff, hit_in;
   status_type          status_ff, status_in;
   logic [ID_BITS-1:0]  given_ff, given_in;

   // Result registers.
   status_type          rsp_status_ff, rsp_status_in;
   logic [ID_BITS-1:0]  rsp_given_ff, rsp_given_in;
   logic [CNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic [ID_BITS-1:0]  rsp_hid_ff, rsp_hid_in;
   logic [TAG_BITS-1:0] rsp_htag_ff, rsp_htag_in;

   // Memory port.
   logic               wr_en;
   logic [PTR_W-1:0]   wr_addr;
   logic [WORD_W-1:0]  wr_data;
   logic [PTR_W-1:0]   rd_addr;
   logic [WORD_W-1:0]  rd_data;
   logic [ID_BITS-1:0] rd_id;
   logic               match;
   logic               hit_next;

   rotq_ram #(
      .WIDTH (WORD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_id    = rd_data[WORD_W-1:TAG_BITS];
   assign match    = rd_valid_ff && !hit_ff && (rd_id == target_ff);
   assign hit_next = hit_ff || match;

   assign stat.empty     = (occ_ff == '0);
   assign stat.few       = (occ_ff <= CNT_W'(1));
   assign stat.scan_last = ({1'b0, scan_idx_ff} + 1'b1) == (PTR_W + 1)'(occ_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= LAST_SLOT;
         occ_ff      <= '0;
         next_id_ff  <= ID_BITS'(1);
         spent_ff    <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         occ_ff      <= occ_in;
         next_id_ff  <= next_id_in;
         spent_ff    <= spent_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff        <= tag_in;
      target_ff     <= target_in;
      scan_idx_ff   <= scan_idx_in;
      rd_idx_ff     <= rd_idx_in;
      hit_ff        <= hit_in;
      status_ff     <= status_in;
      given_ff      <= given_in;
      rsp_status_ff <= rsp_status_in;
      rsp_given_ff  <= rsp_given_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_hid_ff    <= rsp_hid_in;
      rsp_htag_ff   <= rsp_htag_in;
   end

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      occ_in        = occ_ff;
      next_id_in    = next_id_ff;
      spent_in      = spent_ff;
      tag_in        = tag_ff;
      target_in     = target_ff;
      scan_idx_in   = scan_idx_ff;
      rd_idx_in     = scan_idx_ff;
      rd_valid_in   = cmd.scan_issue;
      hit_in        = hit_ff;
      status_in     = status_ff;
      given_in      = given_ff;
      rsp_status_in = rsp_status_ff;
      rsp_given_in  = rsp_given_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_hid_in    = rsp_hid_ff;
      rsp_htag_in   = rsp_htag_ff;
      wr_en         = 1'b0;
      wr_addr       = wrap_inc(tail_ff);
      wr_data       = {next_id_ff, tag_ff};
      rd_addr       = head_ff;

      if (cmd.load) begin
         tag_in      = req_driver_tag;
         target_in   = req_target_id;
         scan_idx_in = '0;
         hit_in      = 1'b0;
         status_in   = ST_OK;
         given_in    = '0;
      end

      if (cmd.reg_exec) begin
         if (occ_ff == FULL_CNT) begin
            status_in = ST_FULL;
         end else if (spent_ff) begin
            status_in = ST_EXHAUSTED;
         end else begin
            wr_en    = 1'b1;
            tail_in  = wrap_inc(tail_ff);
            occ_in   = occ_ff + 1'b1;
            given_in = next_id_ff;
            // The id counter stops at its largest value once that is handed out.
            if (next_id_ff == MAX_ID) begin
               spent_in = 1'b1;
            end else begin
               next_id_in = next_id_ff + 1'b1;
            end
         end
      end

      if (cmd.rot_read && stat.few) begin
         status_in = ST_FEW;
      end

      if (cmd.rot_write) begin
         wr_en   = 1'b1;
         wr_data = rd_data;
         head_in = wrap_inc(head_ff);
         tail_in = wrap_inc(tail_ff);
      end

      if (cmd.mark_empty) begin
         status_in = ST_EMPTY;
      end

      if (cmd.scan_issue) begin
         rd_addr     = wrap_add(head_ff, scan_idx_ff);
         scan_idx_in = scan_idx_ff + 1'b1;
      end

      // Once the matching entry is seen, every later entry moves one slot
      // toward the head, into a slot that has already been read.
      if (cmd.scan_proc) begin
         hit_in = hit_next;
         if (rd_valid_ff && hit_ff) begin
            wr_en   = 1'b1;
            wr_addr = wrap_dec(wrap_add(head_ff, rd_idx_ff));
            wr_data = rd_data;
         end
      end

      if (cmd.remove_finish) begin
         if (hit_next) begin
            occ_in  = occ_ff - 1'b1;
            tail_in = wrap_dec(tail_ff);
         end else begin
            status_in = ST_NOTFOUND;
         end
      end

      if (cmd.head_read) begin
         rd_addr = head_ff;
      end

      if (cmd.capture) begin
         rsp_status_in = status_ff;
         rsp_given_in  = given_ff;
         rsp_count_in  = occ_ff;
         if (occ_ff == '0) begin
            rsp_hid_in  = '0;
            rsp_htag_in = '0;
         end else begin
            rsp_hid_in  = rd_id;
            rsp_htag_in = rd_data[TAG_BITS-1:0];
         end
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_assigned_id = rsp_given_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_head_id     = rsp_hid_ff;
   assign rsp_head_tag    = rsp_htag_ff;

endmodule

### hw/rtl/rotating_id_queue_core.sv
// Ring queue of up to QUEUE_DEPTH entries, each an automatically assigned id
// and a tag, stored in one RAM with a single write port and a single registered
// read port. A request is taken only when the block is idle and its result
// has been delivered, so one request is in flight at a time, and the next
// request is taken no earlier than the cycle after the result is taken.
// Remove scans the entries from the head through the RAM read port one per
// cycle and closes the gap behind the matching entry as it goes; it skips the
// scan when the queue is empty, and rotate skips its write with fewer than two
// entries.
// Every result ends with a read of the head slot to report the head entry.
module rotating_id_queue_core #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 16,
   parameter int TAG_BITS    = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_type,
   input  logic [TAG_BITS-1:0]              req_driver_tag,
   input  logic [ID_BITS-1:0]               req_target_id,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output rotq_pkg::status_type             rsp_status,
   output logic [ID_BITS-1:0]               rsp_assigned_id,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0] rsp_entry_count,
   output logic [ID_BITS-1:0]               rsp_head_id,
   output logic [TAG_BITS-1:0]              rsp_head_tag
);
   import rotq_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   rotq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rotq_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_BITS     (ID_BITS),
      .TAG_BITS    (TAG_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_driver_tag  (req_driver_tag),
      .req_target_id   (req_target_id),
      .rsp_status      (rsp_status),
      .rsp_assigned_id (rsp_assigned_id),
      .rsp_entry_count (rsp_entry_count),
      .rsp_head_id     (rsp_head_id),
      .rsp_head_tag    (rsp_head_tag)
   );

endmodule

### tb/tb_rotating_id_queue_core.sv
// Self-checking testbench for the rotating id queue core, driven by a table and random requests.
`timescale 1ns / 100ps

module tb_rotating_id_queue_core;
   import rotq_pkg::*;

   localparam int QDEPTH = 16;
   localparam int TAIL_LATENCY = 32;
   localparam int RANDOM_ITEMS = 1400;
   localparam logic [15:0] LAST_ID = 16'hFFFF;

   typedef struct packed {
      status_type  status;
      logic [15:0] assigned_id;
      logic [4:0]  entry_count;
      logic [15:0] head_id;
      logic [31:0] head_tag;
   } queue_result_type;

   typedef struct packed {
      req_kind_type     kind;
      logic [31:0]      tag;
      logic [15:0]      target;
      logic             has_want;
      queue_result_type want;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_type;
   logic [31:0] req_driver_tag;
   logic [15:0] req_target_id;
   logic        rsp_valid;
   logic        rsp_ready;
   status_type  rsp_status;
   logic [15:0] rsp_assigned_id;
   logic [4:0]  rsp_entry_count;
   logic [15:0] rsp_head_id;
   logic [31:0] rsp_head_tag;

   // Shadow copy of the queue, updated as each request is accepted.
   logic [15:0] q_id [QDEPTH];
   logic [31:0] q_tag [QDEPTH];
   logic [3:0]  q_head = '0;
   logic [3:0]  q_tail = 4'(QDEPTH - 1);
   int          q_fill = 0;
   logic [15:0] id_next = 16'd1;
   bit          ids_gone = 1'b0;

   queue_result_type pending_results [$];
   int               error_count = 0;
   int               random_count = 0;
   bit               sender_steady = 1'b0;
   bit               receiver_steady = 1'b0;

   directed_row_type directed_rows [27] = '{
      '{REQ_REMOVE,   32'h0,         16'h0000, 1'b1,
        '{ST_EMPTY, 16'd0, 5'd0, 16'd0, 32'h0}},
      '{REQ_ROTATE,   32'h0,         16'h0000, 1'b1,
        '{ST_FEW, 16'd0, 5'd0, 16'd0, 32'h0}},
      '{REQ_NONE,     32'hFFFF_FFFF, 16'hFFFF, 1'b1,
        '{ST_OK, 16'd0, 5'd0, 16'd0, 32'h0}},
      '{REQ_REGISTER, 32'hFFFF_FFFF, 16'h0000, 1'b1,
        '{ST_OK, 16'd1, 5'd1, 16'd1, 32'hFFFF_FFFF}},
      '{REQ_REMOVE,   32'h0,         16'h0000, 1'b1,
        '{ST_NOTFOUND, 16'd0, 5'd1, 16'd1, 32'hFFFF_FFFF}},
      '{REQ_REMOVE,   32'h0,         16'hFFFF, 1'b1,
        '{ST_NOTFOUND, 16'd0, 5'd1, 16'd1, 32'hFFFF_FFFF}},
      '{REQ_REMOVE,   32'h0,         16'd1,    1'b1,
        '{ST_OK, 16'd0, 5'd0, 16'd0, 32'h0}},
      '{REQ_REGISTER, 32'h0,         16'h0000, 1'b1,
        '{ST_OK, 16'd2, 5'd1, 16'd2, 32'h0}},
      '{REQ_REGISTER, 32'h8000_0000, 16'h0000, 1'b0, '0},
      '{REQ_REGISTER, 32'h0000_0001, 16'h0000, 1'b0, '0},
      '{REQ_REGISTER, 32'hA5A5_A5A5, 16'h0000, 1'b0, '0},
      '{REQ_REGISTER, 32'h5A5A_5A5A, 16'h0000, 1'b0, '0},
      '{REQ_REGISTER, 32'h1234_5678, 16'h0000, 1'b0, '0},
      '{REQ_REGISTER, 32'hDEAD_BEEF, 16'h0000, 1'b0, '0},
      '{REQ_REGISTER, 32'h0F0F_0F0F, 16'h0000, 1'b0, '0},
      '{REQ_REGISTER, 32'hF0F0_F0F0, 16'h0000, 1'b0, '0},
      '{REQ_REGISTER, 32'h0000_FFFF, 16'h0000, 1'b0, '0},
      '{REQ_REGISTER, 32'hFFFF_0000, 16'h0000, 1'b0, '0},
      '{REQ_REGISTER, 32'h7FFF_FFFF, 16'h0000, 1'b0, '0},
      '{REQ_REGISTER, 32'h3333_3333, 16'h0000, 1'b0, '0},
      '{REQ_REGISTER, 32'hCCCC_CCCC, 16'h0000, 1'b0, '0},
      '{REQ_REGISTER, 32'h0000_0100, 16'h0000, 1'b0, '0},
      '{REQ_REGISTER, 32'h8765_4321, 16'h0000, 1'b0, '0},
      '{REQ_REGISTER, 32'h5555_5555, 16'h0000, 1'b1,
        '{ST_FULL, 16'd0, 5'd16, 16'd2, 32'h0}},
      '{REQ_ROTATE,   32'h0,         16'h0000, 1'b0, '0},
      '{REQ_REMOVE,   32'h0,         16'd9,    1'b0, '0},
      '{REQ_REMOVE,   32'h0,         16'd3,    1'b0, '0}
   };

   rotating_id_queue_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_driver_tag  (req_driver_tag),
      .req_target_id   (req_target_id),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_assigned_id (rsp_assigned_id),
      .rsp_entry_count (rsp_entry_count),
      .rsp_head_id     (rsp_head_id),
      .rsp_head_tag    (rsp_head_tag)
   );

   always #4 clock = ~clock;

   // Applies one request to the shadow queue and returns the response it should produce.
   function automatic queue_result_type next_queue_result(req_kind_type kind,
                                                          logic [31:0] tag,
                                                          logic [15:0] target);
      queue_result_type res;
      logic [15:0]      kept_id [QDEPTH];
      logic [31:0]      kept_tag [QDEPTH];
      int               kept;
      int               walk;
      bit               hit;
      res = '0;
      res.status = ST_OK;
      case (kind)
         REQ_REGISTER: begin
            if (q_fill >= QDEPTH) begin
               res.status = ST_FULL;
            end else if (ids_gone) begin
               res.status = ST_EXHAUSTED;
            end else begin
               q_tail = q_tail + 1'b1;
               q_id[q_tail] = id_next;
               q_tag[q_tail] = tag;
               q_fill++;
               res.assigned_id = id_next;
               if (id_next == LAST_ID) ids_gone = 1'b1;
               else id_next = id_next + 1'b1;
            end
         end
         REQ_ROTATE: begin
            if (q_fill <= 1) begin
               res.status = ST_FEW;
            end else begin
               q_tail = q_tail + 1'b1;
               q_id[q_tail] = q_id[q_head];
               q_tag[q_tail] = q_tag[q_head];
               q_head = q_head + 1'b1;
            end
         end
         REQ_REMOVE: begin
            if (q_fill == 0) begin
               res.status = ST_EMPTY;
            end else begin
               kept = 0;
               hit = 1'b0;
               walk = q_head;
               for (int i = 0; i < q_fill; i++) begin
                  if (!hit && q_id[walk] == target) begin
                     hit = 1'b1;
                  end else begin
                     kept_id[kept] = q_id[walk];
                     kept_tag[kept] = q_tag[walk];
                     kept++;
                  end
                  walk = (walk + 1) % QDEPTH;
               end
               if (!hit) begin
                  res.status = ST_NOTFOUND;
               end else begin
                  // The survivors are packed down to slot zero.
                  for (int i = 0; i < kept; i++) begin
                     q_id[i] = kept_id[i];
                     q_tag[i] = kept_tag[i];
                  end
                  q_head = '0;
                  q_fill = kept;
                  q_tail = (kept == 0) ? 4'(QDEPTH - 1) : 4'(kept - 1);
               end
            end
         end
         default: ;
      endcase
      res.entry_count = 5'(q_fill);
      if (q_fill != 0) begin
         res.head_id = q_id[q_head];
         res.head_tag = q_tag[q_head];
      end
      return res;
   endfunction

   task automatic send_request(req_kind_type kind, logic [31:0] tag, logic [15:0] target,
                               logic has_want, queue_result_type want);
      int               gap;
      queue_result_type predicted;
      gap = sender_steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_driver_tag <= tag;
      req_target_id <= target;
      do @(posedge clock); while (!req_ready);
      predicted = next_queue_result(kind, tag, target);
      pending_results.push_back(has_want ? want : predicted);
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Mostly ids that are live in the queue, so removes usually hit something.
   function automatic logic [15:0] pick_target();
      int roll;
      roll = $urandom_range(0, 9);
      if (q_fill > 0 && roll < 7) return q_id[(q_head + $urandom_range(0, q_fill - 1)) % QDEPTH];
      if (roll == 7) return 16'd0;
      if (roll == 8) return id_next;
      return 16'($urandom());
   endfunction

   task automatic random_request(int reg_weight, int rem_weight);
      int           pick;
      int           roll;
      req_kind_type kind;
      logic [31:0]  tag;
      pick = $urandom_range(0, 99);
      if (pick < 3) kind = REQ_NONE;
      else if (pick < 3 + reg_weight) kind = REQ_REGISTER;
      else if (pick < 3 + reg_weight + rem_weight) kind = REQ_REMOVE;
      else kind = REQ_ROTATE;
      roll = $urandom_range(0, 9);
      tag = (roll == 0) ? 32'h0 : (roll == 1) ? 32'hFFFF_FFFF : $urandom();
      send_request(kind, tag, pick_target(), 1'b0, '0);
      if (kind != REQ_NONE) random_count++;
   endtask

   initial begin : rsp_side
      int stall;
      rsp_ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = receiver_steady ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : rsp_check
      queue_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("response arrived with no request outstanding");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_assigned_id !== want.assigned_id) begin
               $error("assigned_id: expected %0d, got %0d", want.assigned_id, rsp_assigned_id);
               error_count++;
            end
            if (rsp_entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, got %0d", want.entry_count, rsp_entry_count);
               error_count++;
            end
            if (rsp_head_id !== want.head_id) begin
               $error("head_id: expected %0d, got %0d", want.head_id, rsp_head_id);
               error_count++;
            end
            if (rsp_head_tag !== want.head_tag) begin
               $error("head_tag: expected %h, got %h", want.head_tag, rsp_head_tag);
               error_count++;
            end
         end
      end
   end

   initial begin : stimulus
      int blk_mode;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = REQ_REGISTER;
      req_driver_tag = '0;
      req_target_id = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].kind, directed_rows[i].tag, directed_rows[i].target,
                      directed_rows[i].has_want, directed_rows[i].want);
      end
      wait_for_results();

      // Each block of requests leans toward growing, churning or shrinking the queue.
      while (random_count < RANDOM_ITEMS) begin
         blk_mode = $urandom_range(0, 2);
         sender_steady = ($urandom_range(0, 3) == 0);
         receiver_steady = ($urandom_range(0, 3) == 0);
         repeat (50) begin
            case (blk_mode)
               0: random_request(60, 20);
               1: random_request(35, 30);
               default: random_request(15, 55);
            endcase
            if ($urandom_range(0, 63) == 0) wait_for_results();
         end
      end

      sender_steady = 1'b0;
      receiver_steady = 1'b0;
      wait_for_results();
      repeat (80) random_request(40, 40);

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_LATENCY) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #100_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

### sim.f
hw/rtl/rotq_pkg.sv
hw/rtl/rotq_ram.sv
hw/rtl/rotq_ctrl.sv
hw/rtl/rotq_dp.sv
hw/rtl/rotating_id_queue_core.sv
tb/tb_rotating_id_queue_core.sv
